### hw/rtl/xms_pkg.sv
// Shared types, character codes and check helpers for the XMODEM block sender.
`default_nettype none
package xms_pkg;

    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_START = 8'h43;
    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] PAD_FULL = 8'h80;

    localparam logic [2:0] KIND_FILE    = 3'd0;
    localparam logic [2:0] KIND_END     = 3'd1;
    localparam logic [2:0] KIND_RX      = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT = 3'd3;
    localparam logic [2:0] KIND_SLOT    = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_START = 3'd1;
    localparam logic [2:0] ERR_START_TO  = 3'd2;
    localparam logic [2:0] ERR_CANCEL    = 3'd3;
    localparam logic [2:0] ERR_REPLY_TO  = 3'd4;

    localparam logic [2:0] PC_START = 3'd0;
    localparam logic [2:0] PC_LOAD  = 3'd1;
    localparam logic [2:0] PC_SEND  = 3'd2;
    localparam logic [2:0] PC_REPLY = 3'd3;
    localparam logic [2:0] PC_DONE  = 3'd4;
    localparam logic [2:0] PC_FAIL  = 3'd5;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_LOAD  = 6'b000010,
        PH_SEND  = 6'b000100,
        PH_REPLY = 6'b001000,
        PH_DONE  = 6'b010000,
        PH_FAIL  = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        SRC_NONE   = 3'd0,
        SRC_CONST  = 3'd1,
        SRC_MEM    = 3'd2,
        SRC_SUM_HI = 3'd3,
        SRC_SUM_LO = 3'd4
    } t_src;

    typedef struct packed {
        logic       tx_valid;
        t_src       src;
        logic [7:0] lit;
        logic       pad_hit;
        logic       tx_last;
        logic       need_data;
        logic [2:0] phase_code;
        logic [2:0] error_code;
        logic       clr;
        logic       crc_mode;
    } t_beat;

    function automatic logic [2:0] phase_to_code(input t_phase ph);
        logic [2:0] c;
        case (ph)
            PH_START: c = PC_START;
            PH_LOAD:  c = PC_LOAD;
            PH_SEND:  c = PC_SEND;
            PH_REPLY: c = PC_REPLY;
            PH_DONE:  c = PC_DONE;
            PH_FAIL:  c = PC_FAIL;
            default:  c = PC_START;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/xmodem_sender_core.sv
// XMODEM block sender top level: sequencer, block buffer and output stage.
// One word in gives one word out. Words are taken every cycle while the output
// side keeps up; a result goes through the buffer read and beat register and
// then the check update and output register. With the output stalled, two
// words are held and the input stalls. Buffer reads and writes share no cycle
// conflict, since a payload byte is always written by an earlier word than the
// one that reads it.
// The buffer is not cleared after reset; pad bytes are supplied by the sequencer.
`default_nettype none
module xmodem_sender_core
    import xms_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_kind,
    input  wire logic [7:0] i_value,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_tx_valid,
    output logic      [7:0] o_tx_byte,
    output logic            o_tx_last,
    output logic            o_need_data,
    output logic      [2:0] o_phase_code,
    output logic      [2:0] o_error_code
);

    localparam int AW = $clog2(BLOCK_BYTES);

    logic          accept;
    logic          busy;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    t_beat         beat;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    xms_ctrl #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_beat      (beat)
    );

    xms_buffer #(
        .DEPTH(BLOCK_BYTES)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    xms_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_beat       (beat),
        .i_rdata      (mem_rdata),
        .i_out_stall  (i_out_stall),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_tx_last    (o_tx_last),
        .o_need_data  (o_need_data),
        .o_phase_code (o_phase_code),
        .o_error_code (o_error_code)
    );

endmodule
`default_nettype wire

### hw/rtl/xms_buffer.sv
// Block buffer memory: one write port, one registered read port.
`default_nettype none
module xms_buffer #(
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [7:0]               o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hw/rtl/xms_ctrl.sv
// Protocol sequencer: phase, counters, buffer addressing and per-word decode.
`default_nettype none
module xms_ctrl
    import xms_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_wdata,
    input  wire logic                           i_accept,
    input  wire logic [2:0]                     i_kind,
    input  wire logic [7:0]                     i_value,
    output logic                                o_mem_we,
    output logic      [$clog2(BLOCK_BYTES)-1:0] o_mem_waddr,
    output logic      [7:0]                     o_mem_wdata,
    output logic                                o_mem_re,
    output logic      [$clog2(BLOCK_BYTES)-1:0] o_mem_raddr,
    output t_beat                               o_beat
);

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam logic [AW-1:0] FILL_LAST = AW'(BLOCK_BYTES - 1);
    localparam logic [7:0]    PAD_NONE  = 8'(BLOCK_BYTES);
    localparam logic [7:0]    IDX_PAY   = 8'd3;
    localparam logic [7:0]    IDX_CHK   = 8'(3 + BLOCK_BYTES);

    t_phase      r_phase, n_phase;
    logic [AW-1:0] r_fill, n_fill;
    logic [7:0]  r_send_idx, n_send_idx;
    logic [7:0]  r_blk, n_blk;
    logic        r_crc, n_crc;
    logic        r_end_seen, n_end_seen;
    logic        r_pad_pend, n_pad_pend;
    logic        r_pad_sent, n_pad_sent;
    logic        r_eot, n_eot;
    logic [2:0]  r_err, n_err;
    logic [7:0]  r_pad_start, n_pad_start;
    logic [7:0]  r_pad_val, n_pad_val;
    logic        r_pkcs;
    logic [7:0]  pay;
    t_beat       beat;

    assign pay = r_send_idx - IDX_PAY;

    always_comb begin
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_send_idx  = r_send_idx;
        n_blk       = r_blk;
        n_crc       = r_crc;
        n_end_seen  = r_end_seen;
        n_pad_pend  = r_pad_pend;
        n_pad_sent  = r_pad_sent;
        n_eot       = r_eot;
        n_err       = r_err;
        n_pad_start = r_pad_start;
        n_pad_val   = r_pad_val;
        o_mem_we    = 1'b0;
        beat        = '0;
        beat.src    = SRC_NONE;
        beat.crc_mode = r_crc;

        case (r_phase)
            PH_START: begin
                if (i_kind == KIND_RX) begin
                    if (i_value == CH_START || i_value == CH_NAK) begin
                        n_crc   = (i_value == CH_START);
                        n_fill  = '0;
                        n_phase = PH_LOAD;
                    end else begin
                        n_err   = ERR_BAD_START;
                        n_phase = PH_FAIL;
                    end
                end else if (i_kind == KIND_TIMEOUT) begin
                    n_err   = ERR_START_TO;
                    n_phase = PH_FAIL;
                end
            end
            PH_LOAD: begin
                if (i_kind == KIND_FILE) begin
                    o_mem_we = i_accept;
                    n_fill   = r_fill + 1'b1;
                    if (r_fill == FILL_LAST) begin
                        n_pad_pend  = 1'b0;
                        n_pad_start = PAD_NONE;
                        n_send_idx  = '0;
                        n_eot       = 1'b0;
                        n_phase     = PH_SEND;
                    end
                end else if (i_kind == KIND_END) begin
                    n_end_seen = 1'b1;
                    n_send_idx = '0;
                    n_phase    = PH_SEND;
                    if (r_fill != '0) begin
                        n_pad_start = 8'(r_fill);
                        n_pad_val   = PAD_NONE - 8'(r_fill);
                        n_pad_pend  = 1'b0;
                        n_eot       = 1'b0;
                    end else if (r_pkcs && !r_pad_sent) begin
                        n_pad_start = '0;
                        n_pad_val   = PAD_FULL;
                        n_pad_pend  = 1'b1;
                        n_eot       = 1'b0;
                    end else begin
                        n_eot = 1'b1;
                    end
                end
            end
            PH_SEND: begin
                if (i_kind == KIND_SLOT) begin
                    beat.tx_valid = 1'b1;
                    if (r_eot) begin
                        beat.src     = SRC_CONST;
                        beat.lit     = CH_EOT;
                        beat.tx_last = (r_send_idx >= 8'd2);
                    end else begin
                        if (r_send_idx == 8'd0) begin
                            beat.src = SRC_CONST;
                            beat.lit = CH_SOH;
                            beat.clr = 1'b1;
                        end else if (r_send_idx == 8'd1) begin
                            beat.src = SRC_CONST;
                            beat.lit = r_blk;
                        end else if (r_send_idx == 8'd2) begin
                            beat.src = SRC_CONST;
                            beat.lit = ~r_blk;
                        end else if (r_send_idx < IDX_CHK) begin
                            beat.src     = SRC_MEM;
                            beat.lit     = r_pad_val;
                            beat.pad_hit = (pay >= r_pad_start);
                        end else if (r_crc && r_send_idx == IDX_CHK) begin
                            beat.src = SRC_SUM_HI;
                        end else begin
                            beat.src = SRC_SUM_LO;
                        end
                        beat.tx_last = r_crc ? (r_send_idx > IDX_CHK)
                                             : (r_send_idx >= IDX_CHK);
                    end
                    n_send_idx = r_send_idx + 8'd1;
                    if (beat.tx_last) begin
                        n_phase = PH_REPLY;
                    end
                end
            end
            PH_REPLY: begin
                if (i_kind == KIND_TIMEOUT) begin
                    n_err   = ERR_REPLY_TO;
                    n_phase = PH_FAIL;
                end else if (i_kind == KIND_RX) begin
                    if (i_value == CH_CAN) begin
                        n_err   = ERR_CANCEL;
                        n_phase = PH_FAIL;
                    end else if (r_eot) begin
                        n_phase = PH_DONE;
                    end else if (i_value == CH_ACK) begin
                        n_blk = r_blk + 8'd1;
                        if (r_pad_pend) begin
                            n_pad_pend = 1'b0;
                            n_pad_sent = 1'b1;
                        end
                        if (r_end_seen) begin
                            n_send_idx = '0;
                            n_eot      = 1'b1;
                            n_phase    = PH_SEND;
                        end else begin
                            n_fill  = '0;
                            n_phase = PH_LOAD;
                        end
                    end else begin
                        n_send_idx = '0;
                        n_eot      = 1'b0;
                        n_phase    = PH_SEND;
                    end
                end
            end
            default: begin
            end
        endcase

        beat.need_data  = (n_phase == PH_LOAD);
        beat.phase_code = phase_to_code(n_phase);
        beat.error_code = n_err;
    end

    assign o_mem_waddr = r_fill;
    assign o_mem_wdata = i_value;
    assign o_mem_re    = i_accept;
    assign o_mem_raddr = pay[AW-1:0];
    assign o_beat      = beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkcs <= 1'b0;
        end else if (i_cfg_we) begin
            r_pkcs <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_fill      <= '0;
            r_send_idx  <= '0;
            r_blk       <= 8'd1;
            r_crc       <= 1'b1;
            r_end_seen  <= 1'b0;
            r_pad_pend  <= 1'b0;
            r_pad_sent  <= 1'b0;
            r_eot       <= 1'b0;
            r_err       <= ERR_NONE;
            r_pad_start <= PAD_NONE;
            r_pad_val   <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_send_idx  <= n_send_idx;
            r_blk       <= n_blk;
            r_crc       <= n_crc;
            r_end_seen  <= n_end_seen;
            r_pad_pend  <= n_pad_pend;
            r_pad_sent  <= n_pad_sent;
            r_eot       <= n_eot;
            r_err       <= n_err;
            r_pad_start <= n_pad_start;
            r_pad_val   <= n_pad_val;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/xms_check.sv
// Output stage: buffer read merge, CRC or sum accumulation and output register.
`default_nettype none
module xms_check
    import xms_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_beat      i_beat,
    input  wire logic [7:0] i_rdata,
    input  wire logic       i_out_stall,
    output logic            o_busy,
    output logic            o_out_valid,
    output logic            o_tx_valid,
    output logic      [7:0] o_tx_byte,
    output logic            o_tx_last,
    output logic            o_need_data,
    output logic      [2:0] o_phase_code,
    output logic      [2:0] o_error_code
);

    logic        r_b_valid;
    t_beat       r_b;
    logic        r_o_valid;
    logic        r_o_txv;
    logic [7:0]  r_o_byte;
    logic        r_o_last;
    logic        r_o_need;
    logic [2:0]  r_o_phase;
    logic [2:0]  r_o_err;
    logic [15:0] r_acc, n_acc;
    logic [15:0] acc_base;
    logic [7:0]  b_byte;
    logic        b_adv;

    assign b_adv  = r_b_valid && (!r_o_valid || !i_out_stall);
    assign o_busy = r_b_valid && r_o_valid && i_out_stall;

    always_comb begin
        acc_base = r_b.clr ? 16'h0000 : r_acc;
        n_acc    = acc_base;
        case (r_b.src)
            SRC_CONST:  b_byte = r_b.lit;
            SRC_MEM:    b_byte = r_b.pad_hit ? r_b.lit : i_rdata;
            SRC_SUM_HI: b_byte = r_acc[15:8];
            SRC_SUM_LO: b_byte = r_acc[7:0];
            default:    b_byte = 8'h00;
        endcase
        if (r_b.src == SRC_MEM) begin
            n_acc = r_b.crc_mode ? crc_byte(acc_base, b_byte)
                                 : {8'h00, acc_base[7:0] + b_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_acc     <= '0;
        end else begin
            if (i_accept) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_o_valid <= 1'b1;
                r_acc     <= n_acc;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b <= i_beat;
        end
        if (b_adv) begin
            r_o_txv   <= r_b.tx_valid;
            r_o_byte  <= b_byte;
            r_o_last  <= r_b.tx_last;
            r_o_need  <= r_b.need_data;
            r_o_phase <= r_b.phase_code;
            r_o_err   <= r_b.error_code;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_tx_valid   = r_o_txv;
    assign o_tx_byte    = r_o_byte;
    assign o_tx_last    = r_o_last;
    assign o_need_data  = r_o_need;
    assign o_phase_code = r_o_phase;
    assign o_error_code = r_o_err;

endmodule
`default_nettype wire
